// ===== hw/rtl/pss_pkg.sv =====
// Package for the parity split sorter: store sizing, word type, sequencer
// states and the ordering compare. No dependencies.
package pss_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef logic signed [31:0] word_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_PLACE,
    ST_ERD,
    ST_ELD
  } state_t;

  // true when a must come out ahead of b: evens descending, then odds ascending
  function automatic logic goes_before(word_t a, word_t b);
    logic res;
    if (a[0] != b[0]) begin
      res = ~a[0];
    end else if (!a[0]) begin
      res = (b < a);
    end else begin
      res = (a < b);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/pss_if.sv =====
// Channel interfaces for the parity split sorter: input word and result word.
// Depends on pss_pkg.
interface pss_in_if;
  import pss_pkg::*;
  logic  valid;
  logic  ready;
  word_t value;
  logic  end_of_batch;
  modport source (output valid, output value, output end_of_batch, input ready);
  modport sink   (input valid, input value, input end_of_batch, output ready);
endinterface

interface pss_out_if;
  import pss_pkg::*;
  logic  valid;
  logic  ready;
  word_t sorted_value;
  logic  last_out;
  logic  overflowed;
  modport source (output valid, output sorted_value, output last_out,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input overflowed, output ready);
endinterface

// ===== hw/rtl/parity_split_sorter.sv =====
// Parity split sorter top level: insertion store in a one-write, one-read
// memory, a single ordering comparator under a small sequencer.
// Depends on pss_pkg and the interfaces in pss_if.sv.
//
//   channel   dir   words
//   in_ch     in    value, end_of_batch
//   out_ch    out   sorted_value, last_out, overflowed
//
// Insertion of a word tests stored entries from the top, one memory read and
// one compare each, shifting up every entry it passes, then writes the word
// in place; a word into an empty store is written at once, one into a full
// store is dropped and flags overflow. Each result is read, then loaded out.
// Reset is synchronous, active low; no clearing pass. in_ch.ready is low
// while a word is being placed or a batch is streaming out; a stalled
// result holds the sequencer in its output load step.
module parity_split_sorter (
  input  logic          clk,
  input  logic          rst_n,
  pss_in_if.sink        in_ch,
  pss_out_if.source     out_ch
);
  import pss_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  addr_t  idx_r, idx_nxt;
  logic   ovf_r, ovf_nxt;
  word_t  v_r, v_nxt;
  logic   last_r, last_nxt;

  logic   out_valid_r, out_valid_nxt;
  word_t  out_val_r, out_val_nxt;
  logic   out_last_r, out_last_nxt;
  logic   out_ovf_r, out_ovf_nxt;

  word_t  mem [MAX_ITEMS];
  word_t  rdata_r;
  logic   we, re;
  addr_t  waddr, raddr;
  word_t  wdata;

  logic   in_acc;
  logic   ahead;
  logic   emit_last;
  logic   out_load;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign ahead     = goes_before(v_r, rdata_r);
  assign emit_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    ovf_nxt       = ovf_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = v_r;
    re            = 1'b0;
    raddr         = idx_r;
    out_load      = 1'b0;
    in_ch.ready   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          v_nxt    = in_ch.value;
          last_nxt = in_ch.end_of_batch;
          if (count_r == CNT_W'(MAX_ITEMS)) begin
            ovf_nxt = 1'b1;
            if (in_ch.end_of_batch) begin
              idx_nxt   = '0;
              state_nxt = ST_ERD;
            end
          end else if (count_r == '0) begin
            we        = 1'b1;
            waddr     = '0;
            wdata     = in_ch.value;
            count_nxt = CNT_W'(1);
            if (in_ch.end_of_batch) begin
              idx_nxt   = '0;
              state_nxt = ST_ERD;
            end
          end else begin
            idx_nxt   = count_r[ADDR_W-1:0];
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        re        = 1'b1;
        raddr     = idx_r - ADDR_W'(1);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        we = 1'b1;
        if (ahead) begin
          wdata   = rdata_r;
          idx_nxt = idx_r - ADDR_W'(1);
          if (idx_r == ADDR_W'(1)) begin
            state_nxt = ST_PLACE;
          end else begin
            state_nxt = ST_RD;
          end
        end else begin
          count_nxt = count_r + CNT_W'(1);
          if (last_r) begin
            idx_nxt   = '0;
            state_nxt = ST_ERD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_PLACE: begin
        we        = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        if (last_r) begin
          idx_nxt   = '0;
          state_nxt = ST_ERD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERD: begin
        re        = 1'b1;
        state_nxt = ST_ELD;
      end
      ST_ELD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_val_nxt   = rdata_r;
          out_last_nxt  = emit_last;
          out_ovf_nxt   = ovf_r;
          if (emit_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = ST_ERD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_val_r;
  assign out_ch.last_out     = out_last_r;
  assign out_ch.overflowed   = out_ovf_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("store count above depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ERD || state_r == ST_ELD) |-> count_r != '0)
    else $error("emitting from empty store");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && emit_last) |=> (count_r == '0 && !ovf_r && state_r == ST_IDLE))
    else $error("store not emptied after last result");

  a_ovf_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> count_r == CNT_W'(MAX_ITEMS))
    else $error("overflow flagged with room left");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLACE) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("placement did not grow store");
`endif

endmodule
